FILE: rtl/ame_pkg.sv
// Shared types and constants for the ARM multiply execute pipeline.
package ame_pkg;

  // Encoding masks for the two multiply groups
  localparam logic [31:0] SHORT_MASK = 32'h0FC0_0090;
  localparam logic [31:0] SHORT_BITS = 32'h0000_0090;
  localparam logic [31:0] LONG_MASK  = 32'h0F80_00F0;
  localparam logic [31:0] LONG_BITS  = 32'h0080_0090;

  // Instruction bit positions
  localparam int unsigned BIT_ACC  = 21;
  localparam int unsigned BIT_SETF = 20;
  localparam int unsigned BIT_SGN  = 22;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    KIND_SHORT,
    KIND_LONG,
    KIND_INVALID
  } kind_t;

  // Decoded operands, stage 1 to stage 2
  typedef struct packed {
    kind_t       kind;
    logic        acc;
    logic        setf;
    logic        sgn;
    logic [3:0]  idx1;
    logic [3:0]  idx2;
    logic [31:0] rm;
    logic [31:0] rs;
    logic [31:0] mid;
    logic [31:0] top;
  } dec_t;

  // Raw product and its fix-up terms, stage 2 to stage 3
  typedef struct packed {
    kind_t       kind;
    logic        setf;
    logic [3:0]  idx1;
    logic [3:0]  idx2;
    logic [63:0] prod;
    logic [32:0] corr;
    logic [63:0] addend;
  } mul_t;

  // Final 64-bit result, stage 3 to stage 4
  typedef struct packed {
    kind_t       kind;
    logic        setf;
    logic [3:0]  idx1;
    logic [3:0]  idx2;
    logic [63:0] res;
  } sum_t;

  // Result item as delivered
  typedef struct packed {
    logic        status;
    logic [3:0]  first_dest_index;
    logic [31:0] first_dest_value;
    logic        second_dest_valid;
    logic [3:0]  second_dest_index;
    logic [31:0] second_dest_value;
    logic        flags_write;
    logic        flag_negative;
    logic        flag_zero;
  } res_t;

endpackage

FILE: rtl/ame_decode.sv
// Stage 1: decode the instruction word and register the operands.
module ame_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instruction,
  input  logic [31:0]        rm_value,
  input  logic [31:0]        rs_value,
  input  logic [31:0]        mid_reg_value,
  input  logic [31:0]        top_reg_value,
  output logic               out_valid,
  input  logic               out_ready,
  output ame_pkg::dec_t      out_data
);

  ame_pkg::dec_t dec_next;

  // Classify the encoding and pick destination indices
  always_comb begin
    dec_next      = '0;
    dec_next.acc  = instruction[ame_pkg::BIT_ACC];
    dec_next.setf = instruction[ame_pkg::BIT_SETF];
    dec_next.rm   = rm_value;
    dec_next.rs   = rs_value;
    dec_next.mid  = mid_reg_value;
    dec_next.top  = top_reg_value;
    unique if ((instruction & ame_pkg::SHORT_MASK) == ame_pkg::SHORT_BITS) begin
      dec_next.kind = ame_pkg::KIND_SHORT;
      dec_next.idx1 = instruction[19:16];
    end else if ((instruction & ame_pkg::LONG_MASK) == ame_pkg::LONG_BITS) begin
      dec_next.kind = ame_pkg::KIND_LONG;
      dec_next.sgn  = instruction[ame_pkg::BIT_SGN];
      dec_next.idx1 = instruction[15:12];
      dec_next.idx2 = instruction[19:16];
    end else begin
      dec_next.kind = ame_pkg::KIND_INVALID;
    end
  end

  // Advance when the slot is empty or draining
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec_next;
    end
  end

endmodule

FILE: rtl/ame_mult.sv
// Stage 2: 32x32 unsigned product, signed fix-up term and accumulate operand.
module ame_mult (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ame_pkg::dec_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ame_pkg::mul_t      out_data
);

  ame_pkg::mul_t mul_next;
  logic          is_long;
  logic [32:0]   corr_a;
  logic [32:0]   corr_b;

  assign is_long = (in_data.kind == ame_pkg::KIND_LONG);

  // Signed product = unsigned product minus (sign-weighted operands << 32)
  assign corr_a = (is_long && in_data.sgn && in_data.rm[31]) ? {1'b0, in_data.rs} : '0;
  assign corr_b = (is_long && in_data.sgn && in_data.rs[31]) ? {1'b0, in_data.rm} : '0;

  always_comb begin
    mul_next      = '0;
    mul_next.kind = in_data.kind;
    mul_next.setf = in_data.setf;
    mul_next.idx1 = in_data.idx1;
    mul_next.idx2 = in_data.idx2;
    mul_next.prod = {32'b0, in_data.rm} * {32'b0, in_data.rs};
    mul_next.corr = corr_a + corr_b;
    // Short forms add Rn, long forms add {RdHi,RdLo}
    if (in_data.acc) begin
      mul_next.addend = is_long ? {in_data.top, in_data.mid} : {32'b0, in_data.mid};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= mul_next;
    end
  end

endmodule

FILE: rtl/ame_accum.sv
// Stage 3: apply the signed fix-up and add the accumulate operand.
module ame_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ame_pkg::mul_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ame_pkg::sum_t      out_data
);

  ame_pkg::sum_t sum_next;

  // Fix-up lands in the high word only; its carry out of bit 63 drops
  always_comb begin
    sum_next      = '0;
    sum_next.kind = in_data.kind;
    sum_next.setf = in_data.setf;
    sum_next.idx1 = in_data.idx1;
    sum_next.idx2 = in_data.idx2;
    sum_next.res  = in_data.prod + in_data.addend - {in_data.corr[31:0], 32'b0};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sum_next;
    end
  end

endmodule

FILE: rtl/ame_flags.sv
// Stage 4: form N/Z flags, mask unused fields and hold the result item.
module ame_flags (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ame_pkg::sum_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ame_pkg::res_t      out_data
);

  ame_pkg::res_t res_next;
  logic          lo_zero;
  logic          hi_zero;

  assign lo_zero = (in_data.res[31:0] == '0);
  assign hi_zero = (in_data.res[63:32] == '0);

  // Build the result item by kind
  always_comb begin
    res_next = '0;
    unique case (in_data.kind)
      ame_pkg::KIND_SHORT: begin
        res_next.first_dest_index = in_data.idx1;
        res_next.first_dest_value = in_data.res[31:0];
        if (in_data.setf) begin
          res_next.flags_write   = 1'b1;
          res_next.flag_negative = in_data.res[31];
          res_next.flag_zero     = lo_zero;
        end
      end
      ame_pkg::KIND_LONG: begin
        res_next.first_dest_index  = in_data.idx1;
        res_next.first_dest_value  = in_data.res[31:0];
        res_next.second_dest_valid = 1'b1;
        res_next.second_dest_index = in_data.idx2;
        res_next.second_dest_value = in_data.res[63:32];
        if (in_data.setf) begin
          res_next.flags_write   = 1'b1;
          res_next.flag_negative = in_data.res[63];
          res_next.flag_zero     = lo_zero && hi_zero;
        end
      end
      default: begin
        res_next.status = 1'b1;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

FILE: rtl/arm_multiply_execute_core.sv
// Top level of the ARM multiply execute pipeline.
//
//   Channel   Dir  Handshake                      Payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  instruction + four register values
//   m_axis    out  m_axis_tvalid / m_axis_tready  destinations, values, flags; status
//
// Four register stages: decode, 32x32 multiply, fix-up and accumulate, flags.
// One item per cycle sustained while m_axis_tready is high.
// Each stage holds its item while the next is full and stalled, and takes a new one
// as soon as its own slot empties, so bubbles close up under back-pressure.
// Synchronous reset clears only the stage valid bits.
module arm_multiply_execute_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // instruction, rm_value, rs_value, mid_reg_value, top_reg_value (32 bits each)
  input  logic [ame_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // first_dest_index, first_dest_value, second_dest_valid, second_dest_index,
  // second_dest_value, flags_write, flag_negative, flag_zero, 4 zero pad bits
  output logic [ame_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status
  output logic [0:0]                         m_axis_tuser
);

  logic          dec_valid;
  logic          dec_ready;
  ame_pkg::dec_t dec_data;
  logic          mul_valid;
  logic          mul_ready;
  ame_pkg::mul_t mul_data;
  logic          sum_valid;
  logic          sum_ready;
  ame_pkg::sum_t sum_data;
  ame_pkg::res_t res_data;

  ame_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .instruction   (s_axis_tdata[31:0]),
    .rm_value      (s_axis_tdata[63:32]),
    .rs_value      (s_axis_tdata[95:64]),
    .mid_reg_value (s_axis_tdata[127:96]),
    .top_reg_value (s_axis_tdata[159:128]),
    .out_valid     (dec_valid),
    .out_ready     (dec_ready),
    .out_data      (dec_data)
  );

  ame_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  ame_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_data)
  );

  ame_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_data)
  );

  // Pack the result item onto the stream
  assign m_axis_tdata = {
    4'b0,
    res_data.flag_zero,
    res_data.flag_negative,
    res_data.flags_write,
    res_data.second_dest_value,
    res_data.second_dest_index,
    res_data.second_dest_valid,
    res_data.first_dest_value,
    res_data.first_dest_index
  };
  assign m_axis_tuser = res_data.status;

endmodule
